FILE: hw/rtl/trie_dictionary_engine_macros.svh
// ----------------------------------------------------------------------------
// trie_dictionary_engine_macros.svh
// assertion macros shared by the trie dictionary engine rtl
// ----------------------------------------------------------------------------
`ifndef TRIE_DICTIONARY_ENGINE_MACROS_SVH
`define TRIE_DICTIONARY_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tde_pkg.sv
// ----------------------------------------------------------------------------
// tde_pkg
// sizes, node row layout and beat types of the trie dictionary engine
// ----------------------------------------------------------------------------
package tde_pkg;

	localparam int NODES    = 1024;
	localparam int ALPHABET = 26;

	localparam int OPCODE_W = 2;
	localparam int LETTER_W = 5;
	localparam int PTR_W    = $clog2(NODES);
	localparam int NF_W     = $clog2(NODES + 1);
	localparam int LIDX_W   = $clog2(ALPHABET);

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [NF_W-1:0]   nf_t;
	typedef logic [LIDX_W-1:0] lidx_t;

	localparam nf_t NODES_NF = nf_t'(NODES);

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_EXACT  = 2'd1,
		OP_PREFIX = 2'd2
	} op_t;

	// one node: end-of-word mark and one child pointer per letter, zero is no child
	typedef struct packed {
		logic                    mark;
		ptr_t [ALPHABET-1:0]     child;
	} row_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [LETTER_W-1:0] letter;
		logic                has_letter;
		logic                last;
	} item_t;

	typedef struct packed {
		logic found;
		logic pool_full;
	} result_t;

endpackage

FILE: hw/rtl/tde_ram.sv
// ----------------------------------------------------------------------------
// tde_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/tde_ctrl.sv
// ----------------------------------------------------------------------------
// tde_ctrl
// walk sequencer: reads a node row, updates it and writes it back
// ----------------------------------------------------------------------------
`include "trie_dictionary_engine_macros.svh"

module tde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tde_pkg::item_t    item,
	output logic              res_valid,
	input  logic              res_take,
	output tde_pkg::result_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LREAD,
		ST_LEND,
		ST_RESP
	} state_t;

	state_t             state_q, state_n;
	tde_pkg::item_t     item_s1, item_n;
	tde_pkg::ptr_t      cursor_q, cursor_n;
	tde_pkg::nf_t       nf_q, nf_n;
	tde_pkg::op_t       word_op_q, word_op_n;
	logic               in_word_q, in_word_n;
	logic               missed_q, missed_n;
	logic               over_q, over_n;
	logic               fresh_q, fresh_n;
	tde_pkg::result_t   res_q, res_n;

	logic               re, we, alloc;
	tde_pkg::ptr_t      raddr, waddr, newest, child;
	tde_pkg::row_t      rdata, row_cur, wdata;
	tde_pkg::lidx_t     lidx;
	logic               fresh_cur, letter_ok, walk, op_known;

	tde_ram #(
		.WIDTH ($bits(tde_pkg::row_t)),
		.DEPTH (tde_pkg::NODES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// the newest node's row is not written until first visited, so it reads as empty
	assign newest    = tde_pkg::ptr_t'(nf_q - 1'b1);
	assign fresh_cur = fresh_q && (cursor_q == newest);
	assign row_cur   = fresh_cur ? '0 : rdata;

	assign lidx      = tde_pkg::lidx_t'(item_s1.letter);
	assign letter_ok = int'(item_s1.letter) < tde_pkg::ALPHABET;
	assign child     = row_cur.child[lidx];
	assign op_known  = (word_op_q == tde_pkg::OP_INSERT) || (word_op_q == tde_pkg::OP_EXACT)
		|| (word_op_q == tde_pkg::OP_PREFIX);
	assign walk      = item_s1.has_letter && op_known && !missed_q && !over_q;

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_RESP);
	assign res        = res_q;

	always_comb begin
		state_n   = state_q;
		item_n    = item_s1;
		cursor_n  = cursor_q;
		nf_n      = nf_q;
		word_op_n = word_op_q;
		in_word_n = in_word_q;
		missed_n  = missed_q;
		over_n    = over_q;
		res_n     = res_q;
		re        = 1'b0;
		raddr     = cursor_q;
		we        = 1'b0;
		waddr     = cursor_q;
		wdata     = row_cur;
		alloc     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					re      = 1'b1;
					item_n  = item;
					state_n = ST_EXEC;
					// first beat of a word restarts the walk at the root
					if (!in_word_q) begin
						raddr     = '0;
						cursor_n  = '0;
						word_op_n = tde_pkg::op_t'(item.opcode);
						missed_n  = 1'b0;
						over_n    = 1'b0;
						in_word_n = 1'b1;
					end
				end
			end
			ST_EXEC: begin
				if (walk) begin
					if (!letter_ok) begin
						missed_n = 1'b1;
					end else if (child != '0) begin
						cursor_n = child;
					end else if (word_op_q == tde_pkg::OP_INSERT) begin
						if (nf_q < tde_pkg::NODES_NF) begin
							alloc             = 1'b1;
							wdata.child[lidx] = tde_pkg::ptr_t'(nf_q);
							cursor_n          = tde_pkg::ptr_t'(nf_q);
							nf_n              = tde_pkg::nf_t'(nf_q + 1'b1);
						end else begin
							over_n = 1'b1;
						end
					end else begin
						missed_n = 1'b1;
					end
					// a fresh row is written out in full on its first visit
					we = alloc || fresh_cur;
				end
				state_n = item_s1.last ? ST_LREAD : ST_IDLE;
			end
			ST_LREAD: begin
				re      = 1'b1;
				state_n = ST_LEND;
			end
			ST_LEND: begin
				res_n     = '0;
				in_word_n = 1'b0;
				state_n   = ST_RESP;
				case (word_op_q)
					tde_pkg::OP_INSERT: begin
						if (over_q) begin
							res_n.pool_full = 1'b1;
						end else if (!missed_q) begin
							we          = 1'b1;
							wdata.mark  = 1'b1;
							res_n.found = 1'b1;
						end
					end
					tde_pkg::OP_EXACT: begin
						res_n.found = !missed_q && row_cur.mark;
					end
					tde_pkg::OP_PREFIX: begin
						res_n.found = !missed_q;
					end
					default: begin
						res_n = '0;
					end
				endcase
			end
			ST_RESP: begin
				if (res_take) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		if (alloc) begin
			fresh_n = 1'b1;
		end else if (we && (waddr == newest)) begin
			fresh_n = 1'b0;
		end else begin
			fresh_n = fresh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cursor_q  <= '0;
			nf_q      <= tde_pkg::nf_t'(1);
			word_op_q <= tde_pkg::OP_INSERT;
			in_word_q <= 1'b0;
			missed_q  <= 1'b0;
			over_q    <= 1'b0;
			fresh_q   <= 1'b1;
		end else begin
			state_q   <= state_n;
			cursor_q  <= cursor_n;
			nf_q      <= nf_n;
			word_op_q <= word_op_n;
			in_word_q <= in_word_n;
			missed_q  <= missed_n;
			over_q    <= over_n;
			fresh_q   <= fresh_n;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_n;
		res_q   <= res_n;
	end

	`TDE_ASSERT_NOW(a_cursor_alloc, in_word_q, tde_pkg::nf_t'(cursor_q) < nf_q, "cursor beyond allocated nodes")
	`TDE_ASSERT_NEXT(a_alloc_step, alloc, (nf_q == $past(nf_q) + 1'b1) && fresh_q, "allocation did not advance pool")
	`TDE_ASSERT_NOW(a_write_state, we, (state_q == ST_EXEC) || (state_q == ST_LEND), "row write outside update step")
	`TDE_ASSERT_NEXT(a_end_result, state_q == ST_LEND, (state_q == ST_RESP) && !in_word_q, "word end gave no result")

endmodule

FILE: hw/rtl/trie_dictionary_engine.sv
// ----------------------------------------------------------------------------
// trie_dictionary_engine
// dictionary of lower-case words kept as a trie in a node pool
// ----------------------------------------------------------------------------
// words come in one letter per item beat on the item channel (item_valid /
// item_ready): opcode is taken from a word's first beat (insert, exact search,
// prefix search), has_letter is low only for an empty word, last closes it.
// each last beat yields one beat on the result channel (result_valid /
// result_ready) with found and pool_full; other beats yield nothing.
// a beat without last goes through one read of the node row in the single
// trie ram, then the update and write back. a last beat goes through the
// walk step, a second row read at the final node, the end-of-word update,
// and the handoff into the output register before the next accept.
// result_valid rises once that handoff has loaded the output register.
// the output register holds one result, so the next word can start while a
// result waits; if the receiver stalls past that, item_ready stays low.
// reset (arst_n low) empties the dictionary at once: the pool fill count goes
// back to one node (the root), and rows of nodes not yet allocated are read
// as empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module trie_dictionary_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [tde_pkg::OPCODE_W-1:0]   opcode,
	input  logic [tde_pkg::LETTER_W-1:0]   letter,
	input  logic                           has_letter,
	input  logic                           last,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           found,
	output logic                           pool_full
);

	tde_pkg::item_t   item;
	tde_pkg::result_t res;
	logic             res_valid, res_take;
	logic             valid_q;
	logic             found_q, pool_full_q;

	assign item.opcode     = opcode;
	assign item.letter     = letter;
	assign item.has_letter = has_letter;
	assign item.last       = last;

	tde_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// output slot takes a new result when empty or being drained
	assign res_take = res_valid && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			found_q     <= res.found;
			pool_full_q <= res.pool_full;
		end
	end

	assign result_valid = valid_q;
	assign found        = found_q;
	assign pool_full    = pool_full_q;

endmodule
